[rtl/core/dc2d_pkg.sv]
// Shared types, constants and constant tables for the day-count-to-date block.
// Used by dc2d_ctrl, dc2d_dp and day_count_to_date; depends on nothing.

package dc2d_pkg;

    // Accepted day-number range and shift to days since 0000-03-01
    localparam logic signed [22:0] DAYS_MIN = -23'sd715509;
    localparam logic signed [22:0] DAYS_MAX = 23'sd2936549;
    localparam logic signed [23:0] SHIFT_TO_MARCH = 24'sd715815;

    // Datapath widths
    localparam int NUM_W   = 22;              // dividend width
    localparam int RECIP_W = 15;              // reciprocal width
    localparam int QUOT_W  = 15;              // quotient estimate width
    localparam int CONST_W = 18;              // divisor width
    localparam int PROD_W  = NUM_W + RECIP_W; // product width

    // Reciprocals are floor(2^NUM_W / divisor); estimate is low by at most one
    localparam int RECIP_SHIFT = NUM_W;

    localparam logic [17:0] DAYS_PER_ERA = 18'd146097;
    localparam logic [17:0] DAYS_PER_ERA_LAST = 18'd146096;

    // Divisor in use by the shared constant divider
    typedef enum logic [1:0] {
        DIV_ERA,    // 400-year era
        DIV_QUAD,   // 4-year cycle correction
        DIV_YEAR,   // year of era
        DIV_MONTH   // month from March
    } dc2d_div_t;

    // Controller to datapath commands
    typedef struct packed {
        logic      load;
        logic      div_mul;
        logic      div_rem;
        logic      div_fix;
        dc2d_div_t div_sel;
        logic      era_set;
        logic      num_set;
        logic      doy_set;
        logic      mpn_set;
        logic      out_load;
    } dc2d_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
    } dc2d_status_t;

    function automatic logic [CONST_W-1:0] div_const(input dc2d_div_t sel);
        logic [CONST_W-1:0] c;
        unique case (sel)
            DIV_ERA:   c = DAYS_PER_ERA;
            DIV_QUAD:  c = 18'd1460;
            DIV_YEAR:  c = 18'd365;
            DIV_MONTH: c = 18'd153;
            default:   c = DAYS_PER_ERA;
        endcase
        return c;
    endfunction

    function automatic logic [RECIP_W-1:0] div_recip(input dc2d_div_t sel);
        logic [RECIP_W-1:0] r;
        unique case (sel)
            DIV_ERA:   r = 15'd28;
            DIV_QUAD:  r = 15'd2872;
            DIV_YEAR:  r = 15'd11491;
            DIV_MONTH: r = 15'd27413;
            default:   r = 15'd28;
        endcase
        return r;
    endfunction

    // First day-of-year (from March 1) of each month index
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] s;
        unique case (mp)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd61;
            4'd3:    s = 9'd92;
            4'd4:    s = 9'd122;
            4'd5:    s = 9'd153;
            4'd6:    s = 9'd184;
            4'd7:    s = 9'd214;
            4'd8:    s = 9'd245;
            4'd9:    s = 9'd275;
            4'd10:   s = 9'd306;
            4'd11:   s = 9'd337;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

endpackage

[rtl/core/dc2d_ctrl.sv]
// Sequencer for the day-count-to-date conversion.
// Uses dc2d_pkg for command and status types; drives dc2d_dp.

module dc2d_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  dc2d_pkg::dc2d_status_t status,
    output dc2d_pkg::dc2d_cmd_t   cmd
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ERA_MUL, ST_ERA_REM, ST_ERA_FIX, ST_ERA_SET,
        ST_QUAD_MUL, ST_QUAD_REM, ST_QUAD_FIX, ST_NUM_SET,
        ST_YEAR_MUL, ST_YEAR_REM, ST_YEAR_FIX, ST_DOY_SET, ST_MPN_SET,
        ST_MON_MUL, ST_MON_REM, ST_MON_FIX,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Advance through the fixed step sequence
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (s_valid) state_next = ST_ERA_MUL;
            ST_ERA_MUL:  state_next = ST_ERA_REM;
            ST_ERA_REM:  state_next = ST_ERA_FIX;
            ST_ERA_FIX:  state_next = ST_ERA_SET;
            ST_ERA_SET:  state_next = ST_QUAD_MUL;
            ST_QUAD_MUL: state_next = ST_QUAD_REM;
            ST_QUAD_REM: state_next = ST_QUAD_FIX;
            ST_QUAD_FIX: state_next = ST_NUM_SET;
            ST_NUM_SET:  state_next = ST_YEAR_MUL;
            ST_YEAR_MUL: state_next = ST_YEAR_REM;
            ST_YEAR_REM: state_next = ST_YEAR_FIX;
            ST_YEAR_FIX: state_next = ST_DOY_SET;
            ST_DOY_SET:  state_next = ST_MPN_SET;
            ST_MPN_SET:  state_next = ST_MON_MUL;
            ST_MON_MUL:  state_next = ST_MON_REM;
            ST_MON_REM:  state_next = ST_MON_FIX;
            ST_MON_FIX:  state_next = ST_DONE;
            ST_DONE:     if (status.out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Decode commands from the current step
    always_comb begin
        cmd = '0;
        cmd.div_sel = dc2d_pkg::DIV_ERA;
        unique case (state_reg)
            ST_IDLE:     cmd.load = s_valid;
            ST_ERA_MUL:  cmd.div_mul = 1'b1;
            ST_ERA_REM:  cmd.div_rem = 1'b1;
            ST_ERA_FIX:  cmd.div_fix = 1'b1;
            ST_ERA_SET:  cmd.era_set = 1'b1;
            ST_QUAD_MUL: begin
                cmd.div_mul = 1'b1;
                cmd.div_sel = dc2d_pkg::DIV_QUAD;
            end
            ST_QUAD_REM: begin
                cmd.div_rem = 1'b1;
                cmd.div_sel = dc2d_pkg::DIV_QUAD;
            end
            ST_QUAD_FIX: begin
                cmd.div_fix = 1'b1;
                cmd.div_sel = dc2d_pkg::DIV_QUAD;
            end
            ST_NUM_SET:  cmd.num_set = 1'b1;
            ST_YEAR_MUL: begin
                cmd.div_mul = 1'b1;
                cmd.div_sel = dc2d_pkg::DIV_YEAR;
            end
            ST_YEAR_REM: begin
                cmd.div_rem = 1'b1;
                cmd.div_sel = dc2d_pkg::DIV_YEAR;
            end
            ST_YEAR_FIX: begin
                cmd.div_fix = 1'b1;
                cmd.div_sel = dc2d_pkg::DIV_YEAR;
            end
            ST_DOY_SET:  cmd.doy_set = 1'b1;
            ST_MPN_SET:  cmd.mpn_set = 1'b1;
            ST_MON_MUL:  begin
                cmd.div_mul = 1'b1;
                cmd.div_sel = dc2d_pkg::DIV_MONTH;
            end
            ST_MON_REM:  begin
                cmd.div_rem = 1'b1;
                cmd.div_sel = dc2d_pkg::DIV_MONTH;
            end
            ST_MON_FIX:  begin
                cmd.div_fix = 1'b1;
                cmd.div_sel = dc2d_pkg::DIV_MONTH;
            end
            ST_DONE:     cmd.out_load = status.out_free;
            default:     cmd = '0;
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Finished item waits while the output register is still occupied
    a_done_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) && !status.out_free |=> state_reg == ST_DONE)
        else $error("sequencer left DONE with output register occupied");

    // A new item only enters once the previous one reached the output register
    a_load_from_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> $past(state_reg) == ST_DONE || $past(state_reg) == ST_IDLE)
        else $error("item accepted while a conversion was in progress");

endmodule

[rtl/core/dc2d_dp.sv]
// Datapath for the day-count-to-date conversion: shared constant divider,
// calendar arithmetic and output register. Uses dc2d_pkg; driven by dc2d_ctrl.

module dc2d_dp (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  dc2d_pkg::dc2d_cmd_t     cmd,
    output dc2d_pkg::dc2d_status_t  status,
    input  logic signed [22:0]      s_day_number,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [13:0]             m_year,
    output logic [3:0]              m_month,
    output logic [4:0]              m_day_of_month
);

    logic [dc2d_pkg::NUM_W-1:0]   div_n_reg,  div_n_next;
    logic [dc2d_pkg::PROD_W-1:0]  prod_reg,   prod_next;
    logic [dc2d_pkg::QUOT_W-1:0]  q_reg,      q_next;
    logic [dc2d_pkg::NUM_W-1:0]   r_reg,      r_next;
    logic [4:0]                   era_reg,    era_next;
    logic [17:0]                  doe_reg,    doe_next;
    logic [8:0]                   yoe_reg,    yoe_next;
    logic [8:0]                   doy_reg,    doy_next;
    logic                         m_valid_reg, m_valid_next;
    logic [13:0]                  year_reg,   year_next;
    logic [3:0]                   month_reg,  month_next;
    logic [4:0]                   dom_reg,    dom_next;

    logic [dc2d_pkg::CONST_W-1:0] dconst;
    logic [dc2d_pkg::RECIP_W-1:0] drecip;
    logic signed [22:0]           d_sat;
    logic signed [23:0]           z_wide;
    logic [dc2d_pkg::QUOT_W+dc2d_pkg::CONST_W-1:0] qc;
    logic [2:0]                   quad_cnt;
    logic [18:0]                  num_wide;
    logic [1:0]                   cent_cnt;
    logic [18:0]                  doy_wide;
    logic [3:0]                   mp;
    logic [8:0]                   dom_wide;

    assign dconst = dc2d_pkg::div_const(cmd.div_sel);
    assign drecip = dc2d_pkg::div_recip(cmd.div_sel);

    // Clamp the day number and shift to days since 0000-03-01
    always_comb begin
        priority if (s_day_number < dc2d_pkg::DAYS_MIN) begin
            d_sat = dc2d_pkg::DAYS_MIN;
        end else if (s_day_number > dc2d_pkg::DAYS_MAX) begin
            d_sat = dc2d_pkg::DAYS_MAX;
        end else begin
            d_sat = s_day_number;
        end
        z_wide = {d_sat[22], d_sat} + dc2d_pkg::SHIFT_TO_MARCH;
    end

    // Product of the quotient estimate and the divisor
    assign qc = (dc2d_pkg::QUOT_W + dc2d_pkg::CONST_W)'(prod_reg[dc2d_pkg::PROD_W-1
                -: dc2d_pkg::QUOT_W]) * (dc2d_pkg::QUOT_W + dc2d_pkg::CONST_W)'(dconst);

    // Numerator of the year-of-era division
    always_comb begin
        quad_cnt = 3'(doe_reg >= 18'd36524) + 3'(doe_reg >= 18'd73048)
                 + 3'(doe_reg >= 18'd109572) + 3'(doe_reg >= dc2d_pkg::DAYS_PER_ERA_LAST);
        num_wide = 19'(doe_reg) - 19'(q_reg) + 19'(quad_cnt)
                 - 19'(doe_reg == dc2d_pkg::DAYS_PER_ERA_LAST);
    end

    // Day of year from the year of era
    always_comb begin
        cent_cnt = 2'(q_reg >= 15'd100) + 2'(q_reg >= 15'd200) + 2'(q_reg >= 15'd300);
        doy_wide = 19'(doe_reg) - 19'(q_reg[8:0]) * 19'd365 - 19'(q_reg[8:2])
                 + 19'(cent_cnt);
    end

    // Final date fields
    always_comb begin
        mp       = q_reg[3:0];
        dom_wide = doy_reg - dc2d_pkg::month_start(mp) + 9'd1;
    end

    // Next-state logic of the datapath registers
    always_comb begin
        div_n_next   = div_n_reg;
        prod_next    = prod_reg;
        q_next       = q_reg;
        r_next       = r_reg;
        era_next     = era_reg;
        doe_next     = doe_reg;
        yoe_next     = yoe_reg;
        doy_next     = doy_reg;
        year_next    = year_reg;
        month_next   = month_reg;
        dom_next     = dom_reg;
        m_valid_next = m_valid_reg && !m_ready;

        if (cmd.load) begin
            div_n_next = z_wide[dc2d_pkg::NUM_W-1:0];
        end
        if (cmd.div_mul) begin
            prod_next = dc2d_pkg::PROD_W'(div_n_reg) * dc2d_pkg::PROD_W'(drecip);
        end
        if (cmd.div_rem) begin
            q_next = prod_reg[dc2d_pkg::PROD_W-1 -: dc2d_pkg::QUOT_W];
            r_next = div_n_reg - qc[dc2d_pkg::NUM_W-1:0];
        end
        // Correct an estimate that came out one low
        if (cmd.div_fix && (r_reg >= dc2d_pkg::NUM_W'(dconst))) begin
            q_next = q_reg + dc2d_pkg::QUOT_W'(1);
            r_next = r_reg - dc2d_pkg::NUM_W'(dconst);
        end
        if (cmd.era_set) begin
            era_next   = q_reg[4:0];
            doe_next   = r_reg[17:0];
            div_n_next = dc2d_pkg::NUM_W'(r_reg[17:0]);
        end
        if (cmd.num_set) begin
            div_n_next = dc2d_pkg::NUM_W'(num_wide[17:0]);
        end
        if (cmd.doy_set) begin
            yoe_next = q_reg[8:0];
            doy_next = doy_wide[8:0];
        end
        if (cmd.mpn_set) begin
            div_n_next = (dc2d_pkg::NUM_W'(doy_reg) << 2) + dc2d_pkg::NUM_W'(doy_reg)
                       + dc2d_pkg::NUM_W'(2);
        end
        if (cmd.out_load) begin
            year_next    = 14'(era_reg) * 14'd400 + 14'(yoe_reg) + 14'(mp >= 4'd10);
            month_next   = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
            dom_next     = dom_wide[4:0];
            m_valid_next = 1'b1;
        end
    end

    // Hold payload registers; reset only the output valid
    always_ff @(posedge aclk) begin
        div_n_reg <= div_n_next;
        prod_reg  <= prod_next;
        q_reg     <= q_next;
        r_reg     <= r_next;
        era_reg   <= era_next;
        doe_reg   <= doe_next;
        yoe_reg   <= yoe_next;
        doy_reg   <= doy_next;
        year_reg  <= year_next;
        month_reg <= month_next;
        dom_reg   <= dom_next;
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign m_year          = year_reg;
    assign m_month         = month_reg;
    assign m_day_of_month  = dom_reg;

    // A single correction step must be enough
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_fix |-> {1'b0, r_reg} < {4'b0, dconst, 1'b0})
        else $error("quotient estimate off by more than one");

    // Delivered month and day stay in range
    a_month_range: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> m_month >= 4'd1 && m_month <= 4'd12)
        else $error("month out of range");

    a_day_range: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> m_day_of_month >= 5'd1 && m_day_of_month <= 5'd31)
        else $error("day of month out of range");

endmodule

[rtl/core/day_count_to_date.sv]
// Top level: converts a signed day count from 1960-01-01 to a Gregorian date.
// Depends on dc2d_pkg, dc2d_ctrl and dc2d_dp.
//
//   channel  direction  handshake          payload
//   s_       in         s_valid / s_ready  s_day_number (23b signed)
//   m_       out        m_valid / m_ready  m_year (14b), m_month (4b), m_day_of_month (5b)
//
// One item at a time: the shared constant divider (multiply by reciprocal,
// remainder, correction) runs four times in sequence, with set-up steps between.
// m_valid rises once the finished item has been loaded into the output register.
// Reset (aresetn low, synchronous) clears the sequencer and the output valid.
// A stalled output holds the finished item; the next input item is accepted
// as soon as the result has moved into the output register.

module day_count_to_date (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [22:0] s_day_number,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [13:0]        m_year,
    output logic [3:0]         m_month,
    output logic [4:0]         m_day_of_month
);

    dc2d_pkg::dc2d_cmd_t    cmd;
    dc2d_pkg::dc2d_status_t status;

    dc2d_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    dc2d_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_day_number   (s_day_number),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_year         (m_year),
        .m_month        (m_month),
        .m_day_of_month (m_day_of_month)
    );

endmodule

[test/day_count_to_date_tb.sv]
// Testbench for day_count_to_date: drives signed day numbers through the input
// channel and checks each returned date against its own calendar predictor.
// Depends only on the day_count_to_date RTL and its package.

module day_count_to_date_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Valid day-number range: 0001-01-01 to 9999-12-31
    localparam int FIRST_DAY = -715509;
    localparam int LAST_DAY  = 2936549;
    // Shift from day number to days since 0000-03-01, and days in 400 years
    localparam longint MARCH_SHIFT = 715815;
    localparam longint ERA_DAYS    = 146097;
    // Cycles with no item moved on either channel before the run is declared hung
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_PER_PHASE = 377;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  dom;
    } civil_date_t;

    logic               aclk;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [22:0] s_day_number = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [13:0]        m_year;
    logic [3:0]         m_month;
    logic [4:0]         m_day_of_month;

    civil_date_t expected_dates[$];
    int mismatch_count  = 0;
    int days_sent       = 0;
    int dates_checked   = 0;
    int clamped_sent    = 0;
    int idle_cycles     = 0;
    int src_idle_pct    = 0;
    int snk_idle_pct    = 0;

    day_count_to_date dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_day_number  (s_day_number),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_year        (m_year),
        .m_month       (m_month),
        .m_day_of_month(m_day_of_month)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Civil date for a day number; out-of-range numbers clamp to the range ends
    function automatic civil_date_t date_of_day(input logic signed [22:0] dn);
        longint days, era, day_of_era, year_of_era, yr, day_of_year, mon_idx, mon, dm;
        civil_date_t res;
        days = longint'(dn);
        if (days < FIRST_DAY) days = FIRST_DAY;
        if (days > LAST_DAY) days = LAST_DAY;
        days        = days + MARCH_SHIFT;
        era         = days / ERA_DAYS;
        day_of_era  = days - era * ERA_DAYS;
        year_of_era = (day_of_era - day_of_era / 1460 + day_of_era / 36524
                       - day_of_era / 146096) / 365;
        yr          = year_of_era + era * 400;
        day_of_year = day_of_era - (365 * year_of_era + year_of_era / 4 - year_of_era / 100);
        // Months count from March so that February falls last
        mon_idx     = (5 * day_of_year + 2) / 153;
        dm          = day_of_year - (153 * mon_idx + 2) / 5 + 1;
        mon         = (mon_idx < 10) ? mon_idx + 3 : mon_idx - 9;
        if (mon <= 2) yr = yr + 1;
        res.year  = 14'(yr);
        res.month = 4'(mon);
        res.dom   = 5'(dm);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Receiver: drop ready at random per the current idle rate
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Check results, record accepted day numbers, and watch for a hang
    always @(posedge aclk) begin
        civil_date_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                dates_checked++;
                if (expected_dates.size() == 0) begin
                    report_mismatch($sformatf("unexpected date %0d-%0d-%0d",
                                              m_year, m_month, m_day_of_month));
                end else begin
                    want = expected_dates.pop_front();
                    if (m_year !== want.year)
                        report_mismatch($sformatf("year %0d, expected %0d", m_year, want.year));
                    if (m_month !== want.month)
                        report_mismatch($sformatf("month %0d, expected %0d",
                                                  m_month, want.month));
                    if (m_day_of_month !== want.dom)
                        report_mismatch($sformatf("day %0d, expected %0d",
                                                  m_day_of_month, want.dom));
                end
            end
            if (s_valid && s_ready) begin
                expected_dates.push_back(date_of_day(s_day_number));
                days_sent++;
                if (s_day_number < FIRST_DAY || s_day_number > LAST_DAY) clamped_sent++;
            end
            if ((m_valid && m_ready) || (s_valid && s_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // Send one day number; called and returning at a falling edge
    task automatic send_day(input logic signed [22:0] dn);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_day_number <= dn;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Range ends, one day either side, and the far ends of the 23-bit field
    task automatic test_range_limits();
        send_day(-23'sd4194304);
        send_day(23'(FIRST_DAY - 1));
        send_day(23'(FIRST_DAY));
        send_day(23'(FIRST_DAY + 1));
        send_day(23'(LAST_DAY - 1));
        send_day(23'(LAST_DAY));
        send_day(23'(LAST_DAY + 1));
        send_day(23'sd4194303);
    endtask

    // Epoch, the day before it, and leap-rule dates in both directions
    task automatic test_leap_rules();
        send_day(23'sd0);       // 1960-01-01
        send_day(-23'sd1);      // 1959-12-31
        send_day(23'sd1);
        send_day(23'sd59);      // 1960-02-29
        send_day(23'sd60);      // 1960-03-01
        send_day(23'sd365);     // 1960-12-31
        send_day(23'sd366);     // 1961-01-01
        send_day(23'sd14669);   // 2000-02-29, divisible by 400
        send_day(-23'sd21856);  // 1900-02-28, century not leap
        send_day(-23'sd21855);  // 1900-03-01
        send_day(-23'sd365);    // 1959-01-01
    endtask

    // Mostly valid dates, some near the range ends, some raw 23-bit values
    task automatic test_random_dates(input int count);
        int pick;
        logic signed [22:0] dn;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 70)
                dn = 23'(int'($urandom_range(LAST_DAY - FIRST_DAY)) + FIRST_DAY);
            else if (pick < 78)
                dn = 23'(FIRST_DAY + int'($urandom_range(800)) - 20);
            else if (pick < 86)
                dn = 23'(LAST_DAY - int'($urandom_range(800)) + 20);
            else
                dn = 23'($urandom());
            send_day(dn);
        end
    endtask

    initial begin
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Phase one: sender idles a quarter of the time, receiver over half
        src_idle_pct = 25;
        snk_idle_pct = 56;
        test_range_limits();
        test_leap_rules();
        test_random_dates(RANDOM_PER_PHASE);

        // Phase two: rates swapped
        src_idle_pct = 56;
        snk_idle_pct = 25;
        test_random_dates(RANDOM_PER_PHASE);

        // Phase three: full rate on both sides
        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random_dates(RANDOM_PER_PHASE);

        s_valid <= 1'b0;
        while (expected_dates.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        $display("Converted %0d day numbers (%0d outside the valid range, clamped),",
                 days_sent, clamped_sent);
        $display("checked %0d dates under three idle patterns; %0d mismatches.",
                 dates_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
